### hdl/spm_pkg.sv
package spm_pkg;

    localparam int unsigned WordW = 64;
    localparam int unsigned HalfW = 32;

    localparam logic [WordW-1:0] MixMulA   = 64'hbf58476d1ce4e5b9;
    localparam logic [WordW-1:0] MixMulB   = 64'h94d049bb133111eb;
    localparam logic [WordW-1:0] GoldenInc = 64'h9e3779b97f4a7c15;

    localparam int unsigned ShiftA = 30;
    localparam int unsigned ShiftB = 27;
    localparam int unsigned ShiftC = 31;

    typedef logic [WordW-1:0] t_word;

    // function codes
    localparam logic [1:0] FN_RESEED  = 2'd0;
    localparam logic [1:0] FN_RAW     = 2'd1;
    localparam logic [1:0] FN_UNIFORM = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_ZERO_IDENT = 2'd1;
    localparam logic [1:0] ST_ZERO_BOUND = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_BUILD_SEED   = 2'd0;
    localparam logic [1:0] REG_ENTITY_IDENT = 2'd1;
    localparam logic [1:0] REG_STREAM_IDENT = 2'd2;

endpackage

### hdl/spm_mul.sv
// Low 64 bits of a 64x64 product from one shared 32x32 multiplier.
module spm_mul
    import spm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_word i_a,
    input  t_word i_b,
    output logic  o_done,
    output t_word o_prod
);

    t_word             r_a;
    t_word             r_b;
    t_word             r_prod;
    t_word             r_acc;
    logic [1:0]        r_step;
    logic              r_busy;
    logic              r_done;
    logic [HalfW-1:0]  op_x;
    logic [HalfW-1:0]  op_y;

    // partial products: lo*lo, lo*hi, hi*lo (hi*hi falls off the top)
    always_comb begin
        case (r_step)
            2'd0: begin
                op_x = r_a[HalfW-1:0];
                op_y = r_b[HalfW-1:0];
            end
            2'd1: begin
                op_x = r_a[HalfW-1:0];
                op_y = r_b[WordW-1:HalfW];
            end
            default: begin
                op_x = r_a[WordW-1:HalfW];
                op_y = r_b[HalfW-1:0];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_step <= 2'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                // operands are 32 bits wide, zero-extended to the full product
                r_prod <= t_word'(op_x) * t_word'(op_y);
                r_step <= r_step + 2'd1;
                case (r_step)
                    2'd0: ;
                    2'd1: r_acc <= r_prod;
                    default: r_acc[WordW-1:HalfW] <= r_acc[WordW-1:HalfW] + r_prod[HalfW-1:0];
                endcase
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

### hdl/spm_div.sv
// Restoring remainder, one bit per cycle. Divisor must be non-zero.
module spm_div
    import spm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_word i_num,
    input  t_word i_den,
    output logic  o_done,
    output t_word o_rem
);

    localparam int unsigned CntW = $clog2(WordW);

    t_word             r_num;
    t_word             r_den;
    t_word             r_rem;
    logic [CntW-1:0]   r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [WordW:0]    trial;
    logic [WordW:0]    diff;

    assign trial = {r_rem, r_num[WordW-1]};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_num <= {r_num[WordW-2:0], 1'b0};
                if (!diff[WordW]) begin
                    r_rem <= diff[WordW-1:0];
                end else begin
                    r_rem <= trial[WordW-1:0];
                end
                r_cnt <= r_cnt + CntW'(1);
                if (&r_cnt) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

### hdl/splitmix64_stream_generator.sv
// SplitMix64 stream generator with an identity-derived seed.
// Config channel (i_cfg_valid/o_cfg_ready, always ready): index 0 build seed,
// 1 entity id, 2 stream id; index 3 is dropped. Write only while idle.
// Input channel (i_in_valid/o_in_ready): one word with i_func and
// i_upper_bound. Output channel (o_out_valid/i_out_ready): one word per input
// word with o_value and o_status.
// One word at a time: o_in_ready is high only while the sequencer is idle.
// All mixing runs through one shared 32x32 multiplier: a 64-bit multiply is
// a start, four partial-product steps and done, and a finalizer is two of
// them. A raw draw runs one finalizer, a reseed three, a uniform draw one
// finalizer plus a bit-serial remainder; errors and func 3 go straight to
// the output state. A new input word is taken only after S_OUT has loaded
// the output register and the sequencer is idle again.
// A stalled receiver holds the finished word in the output register; the
// next result waits in the sequencer and o_in_ready stays low until then.
// Reset clears the generator state and all config registers to zero and
// empties the output register.
module splitmix64_stream_generator
    import spm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [63:0] i_upper_bound,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_value,
    output logic [1:0]  o_status
);

    typedef enum logic [2:0] {
        S_IDLE, S_MIX_A, S_WAIT_A, S_MIX_B, S_WAIT_B, S_DIV, S_WAIT_DIV, S_OUT
    } t_state;

    // which finalizer pass is running
    typedef enum logic [1:0] {
        PH_ENT, PH_STR, PH_SEED, PH_DRAW
    } t_phase;

    t_state      r_state;
    t_phase      r_phase;
    t_word       r_seed;
    t_word       r_entity;
    t_word       r_stream;
    t_word       r_gen;
    t_word       r_x;        // finalizer operand / intermediate
    t_word       r_acc;      // mixed entity id during reseed
    t_word       r_bound;
    logic [1:0]  r_func;
    t_word       r_res_value;
    logic [1:0]  r_res_status;
    logic        r_out_valid;
    t_word       r_value;
    logic [1:0]  r_status;

    logic        mul_start;
    t_word       mul_a;
    t_word       mul_b;
    logic        mul_done;
    t_word       mul_prod;
    logic        div_start;
    logic        div_done;
    t_word       div_rem;
    t_word       gen_next;
    t_word       fin;
    logic        out_free;

    assign gen_next  = r_gen + GoldenInc;
    assign fin       = mul_prod ^ (mul_prod >> ShiftC);
    assign out_free  = !r_out_valid || i_out_ready;

    assign mul_start = (r_state == S_MIX_A) || (r_state == S_MIX_B);
    assign mul_a     = (r_state == S_MIX_A) ? (r_x ^ (r_x >> ShiftA)) : r_x;
    assign mul_b     = (r_state == S_MIX_A) ? MixMulA : MixMulB;
    assign div_start = (r_state == S_DIV);

    spm_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    spm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_x),
        .i_den   (r_bound),
        .o_done  (div_done),
        .o_rem   (div_rem)
    );

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed   <= '0;
            r_entity <= '0;
            r_stream <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_BUILD_SEED:   r_seed   <= i_cfg_data;
                REG_ENTITY_IDENT: r_entity <= i_cfg_data;
                REG_STREAM_IDENT: r_stream <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_ENT;
            r_gen       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_func       <= i_func;
                        r_bound      <= i_upper_bound;
                        r_res_value  <= '0;
                        r_res_status <= ST_OK;
                        case (i_func)
                            FN_RESEED: begin
                                if (r_entity == '0 || r_stream == '0) begin
                                    r_res_status <= ST_ZERO_IDENT;
                                    r_state      <= S_OUT;
                                end else begin
                                    r_x     <= r_entity;
                                    r_phase <= PH_ENT;
                                    r_state <= S_MIX_A;
                                end
                            end
                            FN_RAW: begin
                                r_gen   <= gen_next;
                                r_x     <= gen_next;
                                r_phase <= PH_DRAW;
                                r_state <= S_MIX_A;
                            end
                            FN_UNIFORM: begin
                                if (i_upper_bound == '0) begin
                                    r_res_status <= ST_ZERO_BOUND;
                                    r_state      <= S_OUT;
                                end else begin
                                    r_gen   <= gen_next;
                                    r_x     <= gen_next;
                                    r_phase <= PH_DRAW;
                                    r_state <= S_MIX_A;
                                end
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_MIX_A: r_state <= S_WAIT_A;
                S_WAIT_A: begin
                    if (mul_done) begin
                        r_x     <= mul_prod ^ (mul_prod >> ShiftB);
                        r_state <= S_MIX_B;
                    end
                end
                S_MIX_B: r_state <= S_WAIT_B;
                S_WAIT_B: begin
                    if (mul_done) begin
                        case (r_phase)
                            PH_ENT: begin
                                r_acc   <= fin;
                                r_x     <= r_stream;
                                r_phase <= PH_STR;
                                r_state <= S_MIX_A;
                            end
                            PH_STR: begin
                                r_x     <= r_seed ^ r_acc ^ fin;
                                r_phase <= PH_SEED;
                                r_state <= S_MIX_A;
                            end
                            PH_SEED: begin
                                r_gen   <= fin;
                                r_state <= S_OUT;
                            end
                            default: begin
                                if (r_func == FN_RAW) begin
                                    r_res_value <= fin;
                                    r_state     <= S_OUT;
                                end else begin
                                    r_x     <= fin;
                                    r_state <= S_DIV;
                                end
                            end
                        endcase
                    end
                end
                S_DIV: r_state <= S_WAIT_DIV;
                S_WAIT_DIV: begin
                    if (div_done) begin
                        r_res_value <= div_rem;
                        r_state     <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_value     <= r_res_value;
                        r_status    <= r_res_status;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_status    = r_status;

endmodule

### tb/tb.sv
module tb;
    import spm_pkg::*;

    // func 3 has no package name; the block answers it with a zero word
    localparam logic [1:0] FN_UNUSED  = 2'd3;
    // index 3 is decoded by nobody, a write there must change nothing
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam t_word       ALL_ONES      = {WordW{1'b1}};
    localparam t_word       TOP_BIT       = t_word'(1) << (WordW - 1);
    localparam int unsigned CLK_PERIOD    = 12;
    localparam int unsigned RESET_CYCLES  = 6;
    localparam int unsigned SEG_WORDS     = 50;
    localparam int unsigned SEG_COUNT     = 9;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned MAX_REPORTS   = 10;
    // hard limit, well above what ~480 words plus stalls need
    localparam int unsigned LIMIT_CYCLES  = 500000;

    typedef struct packed {
        logic [1:0] func;
        t_word      bound;
    } t_gen_word;

    typedef struct packed {
        t_word      value;
        logic [1:0] status;
    } t_draw_word;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic [1:0]  i_cfg_index   = '0;
    logic [63:0] i_cfg_data    = '0;
    logic        i_in_valid    = 1'b0;
    logic [1:0]  i_func        = '0;
    logic [63:0] i_upper_bound = '0;
    logic        i_out_ready   = 1'b0;
    logic        o_cfg_ready;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [63:0] o_value;
    logic [1:0]  o_status;

    // words waiting for the driver, and draws waiting for the block
    t_gen_word   pending_words[$];
    t_draw_word  expected_draws[$];
    t_gen_word   next_word;
    t_draw_word  want;

    // shadow of the generator: config registers and 64-bit state
    t_word       model_seed   = '0;
    t_word       model_entity = '0;
    t_word       model_stream = '0;
    t_word       model_state  = '0;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned n_issued      = 0;
    int unsigned n_checked     = 0;
    int unsigned n_errors      = 0;
    int unsigned hold_left     = 0;
    logic        hold_wanted   = 1'b0;
    logic        hold_done     = 1'b0;

    splitmix64_stream_generator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_upper_bound (i_upper_bound),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_value       (o_value),
        .o_status      (o_status)
    );

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    // SplitMix64 finalizer: xor-shift, multiply, twice, then a last xor-shift
    function automatic t_word mix_finalize(input t_word x);
        x = (x ^ (x >> ShiftA)) * MixMulA;
        x = (x ^ (x >> ShiftB)) * MixMulB;
        return x ^ (x >> ShiftC);
    endfunction

    // Works out the word the block owes for one accepted input word and
    // moves the shadow state the same way the block must.
    task automatic splitmix_predict(input logic [1:0] func, input t_word bound);
        t_draw_word res;
        res.value  = '0;
        res.status = ST_OK;
        case (func)
            FN_RESEED: begin
                // a zero identity leaves the state alone
                if (model_entity == '0 || model_stream == '0) begin
                    res.status = ST_ZERO_IDENT;
                end else begin
                    model_state = mix_finalize(model_seed ^ mix_finalize(model_entity)
                                               ^ mix_finalize(model_stream));
                end
            end
            FN_RAW: begin
                model_state = model_state + GoldenInc;
                res.value   = mix_finalize(model_state);
            end
            FN_UNIFORM: begin
                // zero bound: error, no advance
                if (bound == '0) begin
                    res.status = ST_ZERO_BOUND;
                end else begin
                    model_state = model_state + GoldenInc;
                    res.value   = mix_finalize(model_state) % bound;
                end
            end
            default: begin
                // unused code: zero word, state untouched
            end
        endcase
        expected_draws.insert(expected_draws.size(), res);
    endtask

    task automatic log_failure(input string msg);
        n_errors++;
        if (n_errors <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endtask

    // Driver: one word on the input channel at a time. Prediction happens
    // at the accepting edge, so the shadow sees words in block order.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                splitmix_predict(i_func, i_upper_bound);
            end
            // slot frees up when nothing is offered or the offer just went
            if (!i_in_valid || o_in_ready) begin
                if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_word = pending_words.pop_front();
                    i_in_valid    <= 1'b1;
                    i_func        <= next_word.func;
                    i_upper_bound <= next_word.bound;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready. One long hold-off, counted here, lets the output
    // register fill so the block has to stall its input while words queue.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            hold_left   <= 0;
            hold_done   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (hold_wanted && !hold_done) begin
            hold_left   <= HOLD_CYCLES;
            hold_done   <= 1'b1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: every accepted output word against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_checked++;
            if (expected_draws.size() == 0) begin
                log_failure($sformatf("unexpected word: value %h status %0d",
                                      o_value, o_status));
            end else begin
                want = expected_draws.pop_front();
                if (o_value !== want.value) begin
                    log_failure($sformatf("word %0d value: expected %h got %h",
                                          n_checked, want.value, o_value));
                end
                if (o_status !== want.status) begin
                    log_failure($sformatf("word %0d status: expected %0d got %0d",
                                          n_checked, want.status, o_status));
                end
            end
        end
    end

    task automatic queue_word(input logic [1:0] func, input t_word bound);
        t_gen_word w;
        w.func  = func;
        w.bound = bound;
        pending_words.insert(pending_words.size(), w);
        n_issued++;
    endtask

    // wait until every queued word came back, then let the block settle
    task automatic drain();
        while (n_checked != n_issued) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register write, only ever issued while the block is idle
    task automatic set_reg(input logic [1:0] idx, input t_word data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(posedge i_clk);
        end while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_BUILD_SEED:   model_seed   = data;
            REG_ENTITY_IDENT: model_entity = data;
            REG_STREAM_IDENT: model_stream = data;
            default: begin
                // dropped by the block
            end
        endcase
    endtask

    // bounds lean on small and edge values so the remainder does real work
    function automatic t_word pick_bound();
        t_word wide;
        wide = {$urandom, $urandom};
        case ($urandom_range(19))
            0:        return '0;
            1, 2, 3:  return t_word'($urandom_range(16, 1));
            4, 5:     return t_word'(1) << $urandom_range(WordW - 1);
            6:        return ALL_ONES;
            7:        return ALL_ONES - t_word'($urandom_range(15));
            8, 9, 10: return wide >> $urandom_range(WordW - 1);
            default:  return wide;
        endcase
    endfunction

    function automatic t_word pick_reg_value();
        case ($urandom_range(9))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return t_word'(1);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic random_config();
        set_reg(REG_BUILD_SEED, pick_reg_value());
        set_reg(REG_ENTITY_IDENT, pick_reg_value());
        set_reg(REG_STREAM_IDENT, pick_reg_value());
        if ($urandom_range(3) == 0) begin
            set_reg(REG_UNUSED, {$urandom, $urandom});
        end
    endtask

    // mostly draws, an occasional reseed to restart the stream, a few
    // unused codes; the bound is random even where it is ignored
    task automatic random_segment(input int unsigned count);
        int unsigned pick;
        logic [1:0]  func;
        for (int unsigned k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                func = FN_RESEED;
            end else if (pick < 12) begin
                func = FN_UNUSED;
            end else if (pick < 50) begin
                func = FN_RAW;
            end else begin
                func = FN_UNIFORM;
            end
            queue_word(func, pick_bound());
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // first idle mix: sender sparse, receiver choppy
        send_idle_pct <= 21;
        recv_idle_pct <= 54;

        // draws from the zero reset state, zero bound, reseed with zero ids
        queue_word(FN_RAW, '0);
        queue_word(FN_UNIFORM, t_word'(1));
        queue_word(FN_UNIFORM, ALL_ONES);
        queue_word(FN_UNIFORM, '0);
        queue_word(FN_RESEED, ALL_ONES);
        queue_word(FN_UNUSED, ALL_ONES);
        drain();

        // entity still zero, stream set: reseed must fail
        set_reg(REG_STREAM_IDENT, t_word'(1));
        queue_word(FN_RESEED, '0);
        drain();

        // stream zero, entity set: fails again; index 3 is a no-op
        set_reg(REG_ENTITY_IDENT, t_word'(1));
        set_reg(REG_STREAM_IDENT, '0);
        set_reg(REG_UNUSED, ALL_ONES);
        queue_word(FN_RESEED, '0);
        queue_word(FN_RAW, '0);
        drain();

        // everything at all ones
        set_reg(REG_BUILD_SEED, ALL_ONES);
        set_reg(REG_ENTITY_IDENT, ALL_ONES);
        set_reg(REG_STREAM_IDENT, ALL_ONES);
        queue_word(FN_RESEED, '0);
        queue_word(FN_RAW, ALL_ONES);
        queue_word(FN_UNIFORM, t_word'(2));
        queue_word(FN_UNIFORM, TOP_BIT);
        queue_word(FN_UNIFORM, ALL_ONES);
        queue_word(FN_UNIFORM, '0);
        queue_word(FN_UNUSED, '0);
        queue_word(FN_RAW, '0);
        drain();

        // smallest legal identities, zero seed; reseed twice restarts stream
        set_reg(REG_BUILD_SEED, '0);
        set_reg(REG_ENTITY_IDENT, t_word'(1));
        set_reg(REG_STREAM_IDENT, t_word'(1));
        queue_word(FN_RESEED, '0);
        queue_word(FN_RAW, '0);
        queue_word(FN_UNIFORM, t_word'(1));
        queue_word(FN_UNIFORM, t_word'(3));
        queue_word(FN_RESEED, ALL_ONES);
        queue_word(FN_RAW, '0);
        drain();

        // random part: new config per segment, idle mix swapped after the first third,
        // last third runs flat out with the long receiver hold-off
        for (int unsigned seg = 0; seg < SEG_COUNT; seg++) begin
            if (seg == SEG_COUNT / 3) begin
                send_idle_pct <= 54;
                recv_idle_pct <= 21;
            end
            if (seg == 2 * SEG_COUNT / 3) begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
                hold_wanted   <= 1'b1;
            end
            random_config();
            random_segment(SEG_WORDS);
            drain();
        end

        if (n_errors == 0 && expected_draws.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // hard stop if the block hangs
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### sim.f
hdl/spm_pkg.sv
hdl/spm_mul.sv
hdl/spm_div.sv
hdl/splitmix64_stream_generator.sv
tb/tb.sv
